@@ design/lce_pkg.sv @@
// shared types and constants for the linear convolution engine
`timescale 1ns / 1ps

package lce_pkg;

    // width of one convolution output sample
    localparam int ACC_W = 37;

    // width of the request kind field
    localparam int FUNC_W = 2;

    // request kinds
    localparam logic [FUNC_W-1:0] FUNC_TAP  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END  = 2'd2;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic shift;      // move the sample line one cell down
        logic shift_zero; // the sample entering cell 0 is zero
        logic load_tap;   // write a tap into the cell at the tap count
        logic clear;      // zero taps and samples for the next job
    } cell_ctl_t;

endpackage

@@ design/lce_cell.sv @@
// one convolution cell: a tap, a sample stage, a product and a partial sum stage
`timescale 1ns / 1ps

module lce_cell
    import lce_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctl_t                     cell_ctl,
    input  logic                          tap_wr,
    input  logic signed [SAMPLE_BITS-1:0] tap_data,
    input  logic signed [SAMPLE_BITS-1:0] smp_in,
    input  logic signed [ACC_W-1:0]       psum_in,
    output logic signed [SAMPLE_BITS-1:0] smp_out,
    output logic signed [ACC_W-1:0]       psum_out
);

    logic signed [SAMPLE_BITS-1:0]   tap_reg;
    logic signed [SAMPLE_BITS-1:0]   smp_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic signed [ACC_W-1:0]         psum_reg;

    // tap and sample stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            smp_reg <= '0;
        end
        else if (cell_ctl.clear)
        begin
            tap_reg <= '0;
            smp_reg <= '0;
        end
        else
        begin
            if (tap_wr)
            begin
                tap_reg <= tap_data;
            end
            if (cell_ctl.shift)
            begin
                smp_reg <= smp_in;
            end
        end
    end

    // product, then partial sum handed to the next cell
    always_ff @(posedge clk)
    begin
        prod_reg <= tap_reg * smp_reg;
        psum_reg <= psum_in + ACC_W'(prod_reg);
    end

    assign smp_out  = smp_reg;
    assign psum_out = psum_reg;

endmodule

@@ design/lce_ctrl.sv @@
// request sequencer: tap count, drop flag, tail flush and output register
`timescale 1ns / 1ps

module lce_ctrl
    import lce_pkg::*;
#(
    parameter int MAX_TAPS = 32,
    parameter int CNT_W    = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [FUNC_W-1:0]       in_func,
    input  logic signed [ACC_W-1:0] sum,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] out_value,
    output logic                    out_last,
    output logic                    out_empty,
    output logic                    out_dropped,
    output cell_ctl_t               cell_ctl,
    output logic [CNT_W-1:0]        tap_count
);

    // the partial sum has left the last cell after a shift once the wait count reaches WAIT_LAST
    localparam int WAIT_W = $clog2(MAX_TAPS + 2);
    localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(MAX_TAPS + 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_TAPS);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_SEND   = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [WAIT_W-1:0]       wait_reg, wait_next;
    logic [CNT_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    drop_reg, drop_next;
    logic                    flush_reg, flush_next;
    logic signed [ACC_W-1:0] value_reg, value_next;
    logic                    last_reg, last_next;
    logic                    empty_reg, empty_next;
    logic                    dropped_reg, dropped_next;
    logic                    in_fire;
    logic                    out_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        flush_next   = flush_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        empty_next   = empty_reg;
        dropped_next = dropped_reg;
        cell_ctl     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_func)
                        FUNC_TAP:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                cell_ctl.load_tap = 1'b1;
                                count_next        = count_reg + CNT_ONE;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        FUNC_PUSH:
                        begin
                            cell_ctl.shift = 1'b1;
                            wait_next      = '0;
                            flush_next     = 1'b0;
                            state_next     = ST_SETTLE;
                        end
                        FUNC_END:
                        begin
                            if (count_reg <= CNT_ONE)
                            begin
                                // no tail: a single empty result, then clear
                                value_next   = '0;
                                last_next    = 1'b1;
                                empty_next   = 1'b1;
                                dropped_next = drop_reg;
                                flush_next   = 1'b0;
                                state_next   = ST_SEND;
                            end
                            else
                            begin
                                cell_ctl.shift      = 1'b1;
                                cell_ctl.shift_zero = 1'b1;
                                tail_next           = count_reg - CNT_ONE;
                                wait_next           = '0;
                                flush_next          = 1'b1;
                                state_next          = ST_SETTLE;
                            end
                        end
                        default:
                        begin
                            // unknown kind is dropped without effect
                        end
                    endcase
                end
            end
            ST_SETTLE:
            begin
                wait_next = wait_reg + WAIT_W'(1);
                if (wait_reg == WAIT_LAST)
                begin
                    value_next   = sum;
                    last_next    = flush_reg && (tail_reg == CNT_ONE);
                    empty_next   = 1'b0;
                    dropped_next = drop_reg;
                    state_next   = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_fire)
                begin
                    if (last_reg)
                    begin
                        // end of job: clear taps, samples, count and flag
                        cell_ctl.clear = 1'b1;
                        count_next     = '0;
                        drop_next      = 1'b0;
                        flush_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else if (flush_reg)
                    begin
                        cell_ctl.shift      = 1'b1;
                        cell_ctl.shift_zero = 1'b1;
                        tail_next           = tail_reg - CNT_ONE;
                        wait_next           = '0;
                        state_next          = ST_SETTLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            flush_reg <= flush_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        last_reg    <= last_next;
        empty_reg   <= empty_next;
        dropped_reg <= dropped_next;
    end

    assign out_valid   = (state_reg == ST_SEND);
    assign out_value   = value_reg;
    assign out_last    = last_reg;
    assign out_empty   = empty_reg;
    assign out_dropped = dropped_reg;
    assign tap_count   = count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("tap count beyond capacity");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken while a result is pending");

    a_clear_job: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.clear |=> (count_reg == '0) && !drop_reg)
        else $error("job state not cleared after end");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_empty) |-> (out_last && (out_value == '0)))
        else $error("empty result without last or with nonzero value");

    a_flush_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETTLE && flush_reg) |-> (tail_reg != '0))
        else $error("tail flush running with no tail left");

endmodule

@@ design/linear_convolution_engine.sv @@
// linear convolution engine: chain of tap cells with a request sequencer
// a pushed sample or tail step passes the product and partial sum stages of every cell, then the output register
// samples are not overlapped: the partial sum ripple and the output handshake finish before the next push
// tap requests give no result; end flushes taps-1 tail results, or a single empty result with no tail
// the next request is taken only once the pending result has been delivered
// reset (rst_n, async, active low) clears taps, samples, tap count and drop flag
`timescale 1ns / 1ps

module linear_convolution_engine
    import lce_pkg::*;
#(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // value[15:0]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_value[36:0], zero[39:37]
    output logic        m_axis_tlast,  // last
    output logic [1:0]  m_axis_tuser   // empty_res[0], taps_dropped[1]
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int EXT_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

    cell_ctl_t                     cell_ctl;
    logic [CNT_W-1:0]              tap_count;
    logic [EXT_W-1:0]              value_ext;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [SAMPLE_BITS-1:0] head_sample;
    logic signed [SAMPLE_BITS-1:0] smp [MAX_TAPS+1];
    logic signed [ACC_W-1:0]       psum [MAX_TAPS+1];
    logic signed [ACC_W-1:0]       out_value;
    logic                          out_empty;
    logic                          out_dropped;

    // input value masked to the sample width, sign from its top bit
    assign value_ext   = EXT_W'($unsigned(s_axis_tdata));
    assign in_sample   = $signed(value_ext[SAMPLE_BITS-1:0]);
    assign head_sample = cell_ctl.shift_zero ? '0 : in_sample;

    assign smp[0]  = head_sample;
    assign psum[0] = '0;

    // tap cell chain
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        logic tap_wr;

        assign tap_wr = cell_ctl.load_tap && (tap_count == CNT_W'(k));

        lce_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_ctl (cell_ctl),
            .tap_wr   (tap_wr),
            .tap_data (in_sample),
            .smp_in   (smp[k]),
            .psum_in  (psum[k]),
            .smp_out  (smp[k+1]),
            .psum_out (psum[k+1])
        );
    end

    // request sequencer
    lce_ctrl #(
        .MAX_TAPS(MAX_TAPS),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (s_axis_tuser),
        .sum         (psum[MAX_TAPS]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (out_value),
        .out_last    (m_axis_tlast),
        .out_empty   (out_empty),
        .out_dropped (out_dropped),
        .cell_ctl    (cell_ctl),
        .tap_count   (tap_count)
    );

    assign m_axis_tdata = {3'b000, out_value};
    assign m_axis_tuser = {out_dropped, out_empty};

endmodule
